// File: hdl/lc3s_pkg.sv
package lc3s_pkg;

   // data memory size and index width
   localparam int MEM_WORDS = 65536;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   // opcodes
   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_RTI  = 4'd8;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_RES  = 4'd13;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   // instruction classes set by the front end
   typedef enum logic [2:0] {
      CL_REG  = 3'd0,
      CL_LD   = 3'd1,
      CL_LDI  = 3'd2,
      CL_ST   = 3'd3,
      CL_STI  = 3'd4,
      CL_JUMP = 3'd5,
      CL_NONE = 3'd6
   } class_type;

   // decoded item handed from front to back
   typedef struct packed {
      logic [15:0] instr;
      logic [15:0] pc;
      logic [15:0] pc1;
      logic [15:0] target;
      class_type   cls;
   } item_type;

   // one result beat
   typedef struct packed {
      logic [15:0]      next_pc;
      logic [7:0][15:0] regs;
      logic [2:0]       nzp;
   } rsp_type;

   // queue handshake between front and back
   typedef struct packed {
      logic hold;
      logic deq;
   } fe_ctl_type;

   function automatic logic [15:0] sext9(input logic [15:0] v);
      return {{7{v[8]}}, v[8:0]};
   endfunction

   function automatic logic [15:0] sext6(input logic [15:0] v);
      return {{10{v[5]}}, v[5:0]};
   endfunction

   function automatic logic [15:0] sext5(input logic [15:0] v);
      return {{11{v[4]}}, v[4:0]};
   endfunction

   function automatic logic [15:0] sext11(input logic [15:0] v);
      return {{5{v[10]}}, v[10:0]};
   endfunction

   // condition codes of a written value
   function automatic logic [2:0] cc_of(input logic [15:0] v);
      return {v[15], (v == 16'd0), (v != 16'd0) && !v[15]};
   endfunction

   // address lies outside the data memory
   function automatic logic oob(input logic [15:0] a);
      return 17'(a) >= 17'(MEM_WORDS);
   endfunction

endpackage

// File: hdl/lc3s_ram.sv
module lc3s_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/lc3s_front.sv
module lc3s_front
   import lc3s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [15:0] instruction,
   input  logic [15:0] pc,
   output logic        full,
   input  fe_ctl_type  ctl,
   output logic        q_valid,
   output item_type    q_item
);

   item_type   slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   dec;
   logic       acc;
   logic [3:0] op;

   // classify the incoming word
   always_comb begin
      op         = instruction[15:12];
      dec.instr  = instruction;
      dec.pc     = pc;
      dec.pc1    = pc + 16'd1;
      dec.target = pc + 16'd1 + sext9(instruction);
      case (op)
         OP_ADD, OP_AND, OP_NOT, OP_LEA: dec.cls = CL_REG;
         OP_LD, OP_LDR:                  dec.cls = CL_LD;
         OP_LDI:                         dec.cls = CL_LDI;
         OP_ST, OP_STR:                  dec.cls = CL_ST;
         OP_STI:                         dec.cls = CL_STI;
         OP_BR, OP_JSR, OP_JMP:          dec.cls = CL_JUMP;
         default:                        dec.cls = CL_NONE;
      endcase
   end

   assign full    = (cnt_ff == 2'd2) || ctl.hold;
   assign acc     = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = slot_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = wp_ff ^ acc;
      rp_in  = rp_ff ^ (ctl.deq && q_valid);
      cnt_in = cnt_ff + 2'(acc) - 2'(ctl.deq && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (acc) begin
         slot_ff[wp_ff] <= dec;
      end
   end

endmodule

// File: hdl/lc3s_back.sv
module lc3s_back
   import lc3s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output fe_ctl_type ctl,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_EXEC  = 4'b0010,
      S_RD1   = 4'b0100,
      S_RD2   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0][15:0] rf_ff, rf_in;
   logic [2:0]       cc_ff, cc_in;
   item_type         cur_ff, cur_in;
   logic             oob_ff, oob_in;
   logic [MEM_AW-1:0] clr_ff, clr_in;

   logic              ram_we;
   logic [MEM_AW-1:0] ram_waddr, ram_raddr;
   logic [15:0]       ram_wdata, ram_rdata;
   logic [15:0]       raddr16, waddr16;
   logic              wr_ok;

   rsp_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       out_full, push, pop;
   logic [15:0] next_pc;

   logic [15:0] ir, a, b, v, rd;
   logic [3:0]  op;
   logic [2:0]  dr, sr1;
   logic        taken;

   lc3s_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_full = (cnt_ff == 2'd2);
   assign rd       = oob_ff ? 16'd0 : ram_rdata;
   assign ram_raddr = raddr16[MEM_AW-1:0];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rf_in     = rf_ff;
      cc_in     = cc_ff;
      cur_in    = cur_ff;
      oob_in    = oob_ff;
      clr_in    = clr_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      waddr16   = 16'd0;
      wr_ok     = 1'b0;
      ram_wdata = 16'd0;
      raddr16   = 16'd0;
      push      = 1'b0;
      next_pc   = cur_ff.pc1;
      ctl.deq   = 1'b0;
      ctl.hold  = (state_ff == S_CLEAR);
      ir        = q_item.instr;
      op        = q_item.instr[15:12];
      dr        = q_item.instr[11:9];
      sr1       = q_item.instr[8:6];
      a         = 16'd0;
      b         = 16'd0;
      v         = 16'd0;
      taken     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + MEM_AW'(1);
            if (clr_ff == MEM_AW'(MEM_WORDS - 1)) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (q_valid && !out_full) begin
               ctl.deq = 1'b1;
               cur_in  = q_item;
               next_pc = q_item.pc1;
               a       = rf_ff[sr1];
               case (q_item.cls)
                  CL_REG: begin
                     b = ir[5] ? sext5(ir) : rf_ff[ir[2:0]];
                     case (op)
                        OP_ADD:  v = a + b;
                        OP_AND:  v = a & b;
                        OP_NOT:  v = ~a;
                        default: v = q_item.target;
                     endcase
                     rf_in[dr] = v;
                     cc_in     = cc_of(v);
                     push      = 1'b1;
                  end
                  CL_LD, CL_LDI, CL_STI: begin
                     raddr16  = (op == OP_LDR) ? a + sext6(ir) : q_item.target;
                     oob_in   = oob(raddr16);
                     state_in = S_RD1;
                  end
                  CL_ST: begin
                     waddr16   = (op == OP_STR) ? a + sext6(ir) : q_item.target;
                     wr_ok     = 1'b1;
                     ram_wdata = rf_ff[dr];
                     push      = 1'b1;
                  end
                  CL_JUMP: begin
                     case (op)
                        OP_JMP: next_pc = a;
                        OP_JSR: begin
                           next_pc  = ir[11] ? q_item.pc1 + sext11(ir) : a;
                           rf_in[7] = q_item.pc1;
                        end
                        default: begin
                           taken   = (ir[11] && cc_ff[2]) || (ir[10] && cc_ff[1])
                                     || (ir[9] && cc_ff[0]);
                           next_pc = taken ? q_item.target : q_item.pc1;
                        end
                     endcase
                     push = 1'b1;
                  end
                  default: begin
                     next_pc = q_item.pc;
                     push    = 1'b1;
                  end
               endcase
            end
         end
         S_RD1: begin
            case (cur_ff.cls)
               CL_LDI: begin
                  raddr16  = rd;
                  oob_in   = oob(rd);
                  state_in = S_RD2;
               end
               CL_STI: begin
                  waddr16   = rd;
                  wr_ok     = 1'b1;
                  ram_wdata = rf_ff[cur_ff.instr[11:9]];
                  push      = 1'b1;
                  state_in  = S_EXEC;
               end
               default: begin
                  rf_in[cur_ff.instr[11:9]] = rd;
                  cc_in    = cc_of(rd);
                  push     = 1'b1;
                  state_in = S_EXEC;
               end
            endcase
         end
         S_RD2: begin
            rf_in[cur_ff.instr[11:9]] = rd;
            cc_in    = cc_of(rd);
            push     = 1'b1;
            state_in = S_EXEC;
         end
         default: state_in = S_CLEAR;
      endcase
      // data writes drop addresses beyond the memory
      if (wr_ok) begin
         ram_we    = !oob(waddr16);
         ram_waddr = waddr16[MEM_AW-1:0];
      end else if (state_ff != S_CLEAR) begin
         ram_waddr = waddr16[MEM_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rf_ff    <= '0;
         cc_ff    <= 3'd0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rf_ff    <= rf_in;
         cc_ff    <= cc_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      oob_ff <= oob_in;
   end

   // result queue
   assign pop       = rsp_pop && (cnt_ff != 2'd0);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_ff ^ push;
         rp_ff  <= rp_ff ^ pop;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= '{next_pc: next_pc, regs: rf_in, nzp: cc_in};
      end
   end

endmodule

// File: hdl/lc3_instruction_step.sv
// LC-3 single instruction executor.
// Input channel: req_instruction and req_pc form one beat, taken when
// req_push is high and req_full is low. Result channel: while rsp_empty is
// low the oldest result (next pc, r0..r7, n/z/p flags) is on the rsp_ ports
// and it leaves on a cycle with rsp_pop high.
// A two-entry front queue holds decoded beats; the back end executes them
// one at a time against the register file, flags and a single-port-read
// data memory with registered read.
// In the back end, register, jump, branch and store ops finish in S_EXEC; LD, LDR
// and STI also pass through S_RD1, and LDI through S_RD1 and S_RD2 (each memory read adds a state).
// After reset the data memory is cleared one word a cycle, all MEM_WORDS
// words (65536), with req_full held high; registers and flags reset to 0.
// When the receiver stops popping, two results queue up, the back end then
// waits, and the front queue fills until req_full rises.
module lc3_instruction_step
   import lc3s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic        [15:0] req_instruction,
   input  logic        [15:0] req_pc,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic        [15:0] rsp_next_pc,
   output logic signed [15:0] rsp_r0,
   output logic signed [15:0] rsp_r1,
   output logic signed [15:0] rsp_r2,
   output logic signed [15:0] rsp_r3,
   output logic signed [15:0] rsp_r4,
   output logic signed [15:0] rsp_r5,
   output logic signed [15:0] rsp_r6,
   output logic signed [15:0] rsp_r7,
   output logic               rsp_flag_n,
   output logic               rsp_flag_z,
   output logic               rsp_flag_p
);

   fe_ctl_type ctl;
   logic       q_valid;
   item_type   q_item;
   rsp_type    rsp;

   lc3s_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .instruction (req_instruction),
      .pc          (req_pc),
      .full        (req_full),
      .ctl         (ctl),
      .q_valid     (q_valid),
      .q_item      (q_item)
   );

   lc3s_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .ctl       (ctl),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   // unpack the result beat
   assign rsp_next_pc = rsp.next_pc;
   assign rsp_r0      = rsp.regs[0];
   assign rsp_r1      = rsp.regs[1];
   assign rsp_r2      = rsp.regs[2];
   assign rsp_r3      = rsp.regs[3];
   assign rsp_r4      = rsp.regs[4];
   assign rsp_r5      = rsp.regs[5];
   assign rsp_r6      = rsp.regs[6];
   assign rsp_r7      = rsp.regs[7];
   assign rsp_flag_n  = rsp.nzp[2];
   assign rsp_flag_z  = rsp.nzp[1];
   assign rsp_flag_p  = rsp.nzp[0];

endmodule

// File: tb/lc3_instruction_step_tb.sv
`timescale 1ns / 1ps

module lc3_instruction_step_tb
   import lc3s_pkg::*;
();

   // result beat as the predictor sees it
   typedef struct {
      logic [15:0] next_pc;
      logic [15:0] regs [8];
      logic        n, z, p;
   } step_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic [15:0] req_instruction = 0;
   logic [15:0] req_pc = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic [15:0] rsp_next_pc;
   logic signed [15:0] rsp_r0, rsp_r1, rsp_r2, rsp_r3, rsp_r4, rsp_r5, rsp_r6, rsp_r7;
   logic rsp_flag_n, rsp_flag_z, rsp_flag_p;

   lc3_instruction_step DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_instruction(req_instruction), .req_pc(req_pc),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_next_pc(rsp_next_pc),
      .rsp_r0(rsp_r0), .rsp_r1(rsp_r1), .rsp_r2(rsp_r2), .rsp_r3(rsp_r3),
      .rsp_r4(rsp_r4), .rsp_r5(rsp_r5), .rsp_r6(rsp_r6), .rsp_r7(rsp_r7),
      .rsp_flag_n(rsp_flag_n), .rsp_flag_z(rsp_flag_z), .rsp_flag_p(rsp_flag_p)
   );

   always #10 clock = ~clock;

   // shadow machine state
   logic [15:0] shadow_regs [8];
   logic        shadow_n, shadow_z, shadow_p;
   logic [15:0] shadow_mem [int];

   step_result_type pending_results [$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int send_idle_pct = 0;
   int pop_idle_pct = 0;
   longint cycle_count = 0;
   int op_seen [16];

   function automatic logic [15:0] sx(logic [15:0] v, int bits);
      logic [15:0] m;
      m = 16'((32'd1 << bits) - 1);
      v = v & m;
      if (v[bits-1]) v = v | ~m;
      return v;
   endfunction

   function automatic logic [15:0] mem_rd(logic [15:0] a);
      if (32'(a) >= MEM_WORDS) return 16'd0;
      if (shadow_mem.exists(int'(a))) return shadow_mem[int'(a)];
      return 16'd0;
   endfunction

   function automatic void mem_wr(logic [15:0] a, logic [15:0] v);
      if (32'(a) < MEM_WORDS) shadow_mem[int'(a)] = v;
   endfunction

   function automatic void write_dest(logic [2:0] dr, logic [15:0] v);
      shadow_regs[dr] = v;
      shadow_n = v[15];
      shadow_z = (v == 16'd0);
      shadow_p = (v != 16'd0) && !v[15];
   endfunction

   // execute one instruction on the shadow state
   function automatic step_result_type execute_instruction(logic [15:0] ir, logic [15:0] pc);
      step_result_type r;
      logic [15:0] pc1, nxt, operand, a;
      logic [2:0] dr, sr1;
      pc1 = pc + 16'd1;
      dr = ir[11:9];
      sr1 = ir[8:6];
      nxt = pc;
      operand = ir[5] ? sx(ir, 5) : shadow_regs[ir[2:0]];
      case (ir[15:12])
         OP_ADD: begin write_dest(dr, shadow_regs[sr1] + operand); nxt = pc1; end
         OP_AND: begin write_dest(dr, shadow_regs[sr1] & operand); nxt = pc1; end
         OP_NOT: begin write_dest(dr, ~shadow_regs[sr1]); nxt = pc1; end
         OP_LD: begin write_dest(dr, mem_rd(pc1 + sx(ir, 9))); nxt = pc1; end
         OP_LDI: begin
            a = mem_rd(pc1 + sx(ir, 9));
            write_dest(dr, mem_rd(a));
            nxt = pc1;
         end
         OP_LDR: begin write_dest(dr, mem_rd(shadow_regs[sr1] + sx(ir, 6))); nxt = pc1; end
         OP_LEA: begin write_dest(dr, pc1 + sx(ir, 9)); nxt = pc1; end
         OP_ST: begin mem_wr(pc1 + sx(ir, 9), shadow_regs[dr]); nxt = pc1; end
         OP_STI: begin
            a = mem_rd(pc1 + sx(ir, 9));
            mem_wr(a, shadow_regs[dr]);
            nxt = pc1;
         end
         OP_STR: begin mem_wr(shadow_regs[sr1] + sx(ir, 6), shadow_regs[dr]); nxt = pc1; end
         OP_JMP: nxt = shadow_regs[sr1];
         OP_JSR: begin
            nxt = ir[11] ? pc1 + sx(ir, 11) : shadow_regs[sr1];
            shadow_regs[7] = pc1;
         end
         OP_BR: begin
            if ((ir[11] && shadow_n) || (ir[10] && shadow_z) || (ir[9] && shadow_p))
               nxt = pc1 + sx(ir, 9);
            else
               nxt = pc1;
         end
         default: nxt = pc;
      endcase
      r.next_pc = nxt;
      for (int k = 0; k < 8; k++) r.regs[k] = shadow_regs[k];
      r.n = shadow_n;
      r.z = shadow_z;
      r.p = shadow_p;
      return r;
   endfunction

   // send one beat and record its expected result
   task automatic send_instruction(logic [15:0] ir, logic [15:0] pc);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_instruction <= ir;
      req_pc <= pc;
      req_push <= 1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_results.push_back(execute_instruction(ir, pc));
      op_seen[ir[15:12]]++;
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // check helper for one field
   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      step_result_type e;
      logic [15:0] act [8];
      if (!reset && rsp_pop && !rsp_empty) begin
         act = '{rsp_r0, rsp_r1, rsp_r2, rsp_r3, rsp_r4, rsp_r5, rsp_r6, rsp_r7};
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, actual next_pc %h", $time, rsp_next_pc);
         end else begin
            e = pending_results.pop_front();
            check_field("next_pc", e.next_pc, rsp_next_pc);
            for (int k = 0; k < 8; k++)
               check_field($sformatf("r%0d", k), e.regs[k], act[k]);
            check_field("flag_n", 16'(e.n), 16'(rsp_flag_n));
            check_field("flag_z", 16'(e.z), 16'(rsp_flag_z));
            check_field("flag_p", 16'(e.p), 16'(rsp_flag_p));
            beats_checked++;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_pop <= !(pop_idle_pct > 0 && $urandom_range(99) < pop_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("lc3_instruction_step test failed");
         $finish;
      end
   end

   function automatic logic [15:0] rand_word();
      return 16'($urandom_range(65535));
   endfunction

   // directed corners of every opcode and special case
   task automatic test_directed();
      // branches with flags clear after reset are never taken
      send_instruction({OP_BR, 3'b111, 9'h0FF}, 16'h0010);
      send_instruction({OP_ADD, 3'd0, 3'd0, 1'b1, 5'h0F}, 16'h0011);
      send_instruction({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10}, 16'hFFFF);
      send_instruction({OP_ADD, 3'd2, 3'd0, 1'b0, 2'b00, 3'd1}, 16'h0000);
      send_instruction({OP_AND, 3'd3, 3'd1, 1'b1, 5'h00}, 16'h0001);
      send_instruction({OP_AND, 3'd4, 3'd1, 1'b0, 2'b00, 3'd2}, 16'h0002);
      send_instruction({OP_NOT, 3'd5, 3'd3, 6'h3F}, 16'h0003);
      send_instruction({OP_BR, 3'b000, 9'h005}, 16'h0004);
      send_instruction({OP_BR, 3'b100, 9'h100}, 16'h0004);
      send_instruction({OP_ST, 3'd1, 9'h0FF}, 16'hFFF0);
      send_instruction({OP_ST, 3'd5, 9'h100}, 16'h0200);
      send_instruction({OP_LD, 3'd6, 9'h0FF}, 16'hFFF0);
      send_instruction({OP_STI, 3'd2, 9'h0FF}, 16'hFFF0);
      send_instruction({OP_LDI, 3'd7, 9'h0FF}, 16'hFFF0);
      send_instruction({OP_STR, 3'd0, 3'd1, 6'h20}, 16'h0000);
      send_instruction({OP_LDR, 3'd4, 3'd1, 6'h1F}, 16'h0000);
      send_instruction({OP_LEA, 3'd3, 9'h100}, 16'h0000);
      send_instruction({OP_JMP, 3'd0, 3'd5, 6'h00}, 16'h1234);
      send_instruction({OP_JSR, 1'b1, 11'h400}, 16'h0000);
      send_instruction({OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00}, 16'h8000);
      send_instruction({OP_TRAP, 12'h025}, 16'hABCD);
      send_instruction({OP_RTI, 12'h000}, 16'hFFFF);
      send_instruction({OP_RES, 12'h000}, 16'h5555);
      send_instruction({OP_TRAP, 12'hFFF}, 16'hAAAA);
      wait_drained();
   endtask

   // random program slices biased toward memory traffic in a small region
   task automatic test_random(int count);
      logic [15:0] ir, pc;
      for (int i = 0; i < count; i++) begin
         ir = rand_word();
         pc = rand_word();
         if ($urandom_range(3) != 0) begin
            pc = 16'($urandom_range(63));
            if (ir[15:12] inside {OP_LDR, OP_STR} && $urandom_range(1))
               ir[8:6] = 3'($urandom_range(7));
         end
         send_instruction(ir, pc);
         if (i == count / 2) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int k = 0; k < 8; k++) shadow_regs[k] = 0;
      shadow_n = 0;
      shadow_z = 0;
      shadow_p = 0;
      test_directed();
      send_idle_pct = 11;
      pop_idle_pct = 60;
      test_random(600);
      send_idle_pct = 60;
      pop_idle_pct = 11;
      test_random(600);
      send_idle_pct = 0;
      pop_idle_pct = 0;
      test_random(650);
      repeat (10) @(posedge clock);
      $display("sent %0d instruction beats, checked %0d results", beats_sent, beats_checked);
      $display("opcode spread: add %0d ld %0d ldi %0d st %0d sti %0d br %0d", op_seen[OP_ADD],
               op_seen[OP_LD], op_seen[OP_LDI], op_seen[OP_ST], op_seen[OP_STI],
               op_seen[OP_BR]);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("lc3_instruction_step test passed");
      end else begin
         $display("lc3_instruction_step test failed");
      end
      $finish;
   end

endmodule
